// ----- hdl/itoar_pkg.sv -----
`default_nettype none
package itoar_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
   localparam int DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);
   localparam int STEP_CNT_W  = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   localparam logic [CHAR_W-1:0] CH_ZERO           = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS          = 8'h2D;
   localparam logic [CHAR_W-1:0] LETTER_GAP        = 8'd7;
   localparam logic [RADIX_W-1:0] MAX_DECIMAL_DIGIT = RADIX_W'(9);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [RADIX_W-1:0]     divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [RADIX_W-1:0]     remainder;
   } div_stat_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = CH_ZERO + CHAR_W'(d);
      if (d > MAX_DECIMAL_DIGIT) begin
         c = c + LETTER_GAP;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/itoar_divider.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module itoar_divider
   import itoar_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   output div_stat_type      stat
);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [STEP_CNT_W-1:0]  step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [RADIX_W:0]       trial;
   logic                   fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      fits    = trial >= {1'b0, ctrl.divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = ctrl.dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? RADIX_W'(trial - {1'b0, ctrl.divisor}) : trial[RADIX_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_CNT_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule
`default_nettype wire

// ----- hdl/integer_to_ascii_radix_core.sv -----
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_value[31:0] signed
// rsp      out        rsp_valid/rsp_stall  rsp_text_char[7:0], rsp_last
// csr      in         csr_write_enable     csr_write_data[5:0] (radix)
//
// Each digit costs one pass of the shared bit-serial divider.
// Synchronous active-high reset; radix resets to 10, no buffer clearing.
// Input is stalled during reset and from acceptance until the last character
// is in the output register; output stalls simply hold the character register.
module integer_to_ascii_radix_core
   import itoar_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [CHAR_W-1:0]      rsp_text_char,
   output      logic                   rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic [RADIX_W-1:0]     csr_write_data
);

   state_type              state_ff, state_in;
   logic [RADIX_W-1:0]     radix_ff;
   logic [RADIX_W-1:0]     radix_eff;
   logic                   sign_ff, sign_in;
   logic [DIGIT_CNT_W-1:0] count_ff, count_in;
   logic [DIGIT_IDX_W-1:0] ptr_ff, ptr_in;
   logic [CHAR_W-1:0]      digit_ff [DIGIT_DEPTH];
   logic                   digit_we;
   logic [CHAR_W-1:0]      char_ff;
   logic                   last_ff, last_in;
   logic                   valid_ff, valid_in;
   logic                   load;
   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;

   itoar_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   always_comb begin
      radix_eff = radix_ff;
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end
   end

   always_comb begin
      state_in          = state_ff;
      sign_in           = sign_ff;
      count_in          = count_ff;
      ptr_in            = ptr_ff;
      digit_we          = 1'b0;
      load              = 1'b0;
      last_in           = last_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = div_stat.quotient;
      div_ctrl.divisor  = radix_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_ctrl.start    = 1'b1;
               div_ctrl.dividend = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
               sign_in           = req_value[VALUE_WIDTH-1];
               count_in          = '0;
               state_in          = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               digit_we = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_stat.quotient != '0) begin
                  div_ctrl.start = 1'b1;
               end else begin
                  ptr_in   = count_ff[DIGIT_IDX_W-1:0];
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!valid_ff || !rsp_stall) begin
               load = 1'b1;
               if (sign_ff) begin
                  last_in = 1'b0;
                  sign_in = 1'b0;
               end else begin
                  last_in = (ptr_ff == '0);
                  if (ptr_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     ptr_in = ptr_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         valid_ff <= 1'b0;
         sign_ff  <= 1'b0;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sign_ff  <= sign_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= sign_ff ? CH_MINUS : digit_ff[ptr_ff];
      end
      last_ff <= last_in;
      if (digit_we) begin
         digit_ff[count_ff[DIGIT_IDX_W-1:0]] <= digit_char(div_stat.remainder);
      end
   end

   assign req_stall     = reset || (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last      = last_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_divider_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> (div_stat.busy || div_stat.done))
      else $error("divide phase with idle divider");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DIGIT_CNT_W'(DIGIT_DEPTH))
      else $error("digit buffer overflow");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_char == CH_MINUS) |-> !rsp_last)
      else $error("sign flagged as last character");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_DIVIDE && div_stat.busy))
      else $error("accepted transaction did not start a division");

endmodule
`default_nettype wire

// ----- tb/integer_to_ascii_radix_checker.sv -----
`default_nettype none
module integer_to_ascii_radix_checker
   import itoar_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [CHAR_W-1:0]      rsp_text_char,
   input  wire logic                   rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic [RADIX_W-1:0]     csr_write_data,
   output int                          fail_count,
   output int                          outstanding,
   output int                          chars_checked,
   output int                          numbers_seen
);

   localparam logic [CHAR_W-1:0] CHAR_A = "A";

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last;
   } text_result_type;

   text_result_type    expected_text[$];
   logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
   int                 errors    = 0;
   int                 checked   = 0;
   int                 numbers   = 0;

   task automatic report_mismatch(input string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
   endtask

   // Expand one number into its characters, most significant first.
   task automatic predict_text(input logic [VALUE_WIDTH-1:0] value);
      logic [RADIX_W-1:0]     base;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [VALUE_WIDTH-1:0] digit;
      logic [CHAR_W-1:0]      digits[$];
      logic                   last_flag;
      base = radix_reg;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end
      if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      // unsigned negate: the most negative value maps to 2**(W-1)
      magnitude = value[VALUE_WIDTH-1] ? -value : value;
      do begin
         digit = magnitude % base;
         if (digit < 10) begin
            digits.push_front(CH_ZERO + CHAR_W'(digit));
         end else begin
            digits.push_front(CHAR_A + CHAR_W'(digit - 10));
         end
         magnitude = magnitude / base;
      end while (magnitude != 0);
      if (value[VALUE_WIDTH-1]) begin
         expected_text.push_back('{CH_MINUS, 1'b0});
      end
      foreach (digits[i]) begin
         last_flag = (i == digits.size() - 1);
         expected_text.push_back('{digits[i], last_flag});
      end
   endtask

   always @(posedge clock) begin : monitor
      text_result_type want;
      if (reset) begin
         radix_reg = RADIX_RESET;
         expected_text.delete();
      end else begin
         // the model applies the old radix to a transaction taken at the same edge as a radix write
         if (req_valid && !req_stall) begin
            predict_text(req_value);
            numbers++;
         end
         if (csr_write_enable) begin
            radix_reg = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction char=%h last=%b",
                                         rsp_text_char, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_text_char !== want.text_char) begin
                  report_mismatch($sformatf("text_char got %h want %h",
                                            rsp_text_char, want.text_char));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last got %b want %b (char %h)",
                                            rsp_last, want.last, want.text_char));
               end
               checked++;
            end
         end
      end
      fail_count    <= errors;
      outstanding   <= expected_text.size();
      chars_checked <= checked;
      numbers_seen  <= numbers;
   end

endmodule
`default_nettype wire

// ----- tb/integer_to_ascii_radix_core_tb.sv -----
`default_nettype none
module integer_to_ascii_radix_core_tb
   import itoar_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 600;
   localparam int TAIL_CYCLES    = 1200;
   localparam int SEGMENTS       = 4;
   localparam int SEG_ITEMS      = 16;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_value        = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [CHAR_W-1:0]      rsp_text_char;
   logic                   rsp_last;
   logic                   csr_write_enable = 1'b0;
   logic [RADIX_W-1:0]     csr_write_data   = '0;

   int   fail_count;
   int   outstanding;
   int   chars_checked;
   int   numbers_seen;

   int   req_idle_pct  = 0;
   int   rsp_idle_pct  = 0;
   logic hold_request  = 1'b0;
   logic hold_served   = 1'b0;
   int   quiet_cycles  = 0;
   int   radix_writes  = 0;
   int   cur_base      = 10;

   int   sender_idle[3]   = '{24, 83, 0};
   int   receiver_idle[3] = '{83, 24, 0};

   integer_to_ascii_radix_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_text_char    (rsp_text_char),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   integer_to_ascii_radix_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_text_char    (rsp_text_char),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .chars_checked    (chars_checked),
      .numbers_seen     (numbers_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   // outstanding is registered in the checker, so the task steps the clock before looking at it
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_W-1:0] r);
      wait_idle();
      // every number yields output, so the core is idle once the last char is taken
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= r;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      radix_writes++;
      cur_base = int'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] pick_value(input int base);
      longint                 p;
      int                     k;
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 3 * base);
         2: begin
            // near a power of the radix: digit count boundaries
            p = 1;
            k = $urandom_range(1, 31);
            while (k > 0 && p * base <= 64'sh7FFF_FFFF) begin
               p = p * base;
               k--;
            end
            v = VALUE_WIDTH'(p) - VALUE_WIDTH'($urandom_range(0, 1));
         end
         3: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 2) == 0) begin
         v = -v;
      end
      return v;
   endfunction

   initial begin
      int base_pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = sender_idle[0];
      rsp_idle_pct <= receiver_idle[0];

      // directed: reset radix first, then the extremes of the range
      send_value(32'd0);
      send_value(32'd1);
      send_value(-32'sd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd1000000000);
      set_radix(6'd2);
      send_value(32'd0);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(-32'sd1);
      set_radix(6'd36);
      send_value(32'd35);
      send_value(32'd36);
      send_value(-32'sd35);
      send_value(32'h8000_0000);
      set_radix(6'd0);        // saturates to two
      send_value(32'd5);
      set_radix(6'd1);
      send_value(-32'sd6);
      set_radix(6'd37);       // saturates to thirty-six
      send_value(32'd71);
      set_radix(6'd63);
      send_value(32'd1295);
      set_radix(6'd16);
      send_value(32'hDEAD_BEEF);
      send_value(32'h0123_4567);

      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = sender_idle[ph];
         rsp_idle_pct <= receiver_idle[ph];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (ph == 2 && seg == 0) begin
               // long receiver hold-off while items keep coming
               set_radix(6'd16);
               hold_request <= 1'b1;
            end else begin
               base_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(2, 36);
               set_radix(RADIX_W'(base_pick));
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
               send_value(pick_value(cur_base));
            end
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run: %0d numbers converted, %0d characters checked", numbers_seen,
               chars_checked);
      $display("run: %0d radix writes incl. saturating ones, three idle mixes, hold-off",
               radix_writes);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
